>>> rtl/ckv_pkg.sv
`timescale 1ns / 1ps

package ckv_pkg;

    // Input item operation codes
    typedef enum logic [1:0] {
        ACT_GET   = 2'd0,
        ACT_SET   = 2'd1,
        ACT_FILL  = 2'd2,
        ACT_FLUSH = 2'd3
    } action_t;

    // Result item kinds
    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_READ   = 2'd1,
        KIND_FETCH  = 2'd2,
        KIND_WB     = 2'd3
    } kind_t;

    // Capacity register width and reset value
    localparam int          CFG_BITS  = 5;
    localparam logic [4:0]  CFG_RESET = 5'd16;

    // Strobes shared by the key and value RAMs
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } ram_ctl_t;

endpackage

>>> rtl/ckv_ram.sv
`timescale 1ns / 1ps

module ckv_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  ckv_pkg::ram_ctl_t        ctl,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one word; register the read word, hold it while no read is issued
    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[waddr] <= wdata;
        end
        if (ctl.rd_en) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/ckv_ctrl.sv
`timescale 1ns / 1ps

module ckv_ctrl #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [$clog2(ENTRIES+1)-1:0] cap,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_action,
    input  logic [KEY_BITS-1:0]          s_key,
    input  logic [VALUE_BITS-1:0]        s_data_in,
    input  logic                         s_fetch_ok,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_kind,
    output logic [KEY_BITS-1:0]          m_key_out,
    output logic [VALUE_BITS-1:0]        m_data_out,
    output logic                         m_failed,
    output logic                         m_last,
    output ckv_pkg::ram_ctl_t            ram_ctl,
    output logic [$clog2(ENTRIES)-1:0]   ram_waddr,
    output logic [KEY_BITS-1:0]          key_wdata,
    output logic [VALUE_BITS-1:0]        val_wdata,
    output logic [$clog2(ENTRIES)-1:0]   ram_raddr,
    input  logic [KEY_BITS-1:0]          key_rdata,
    input  logic [VALUE_BITS-1:0]        val_rdata
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_LOOK,
        ST_INSTALL,
        ST_HAND,
        ST_VICTIM_WB,
        ST_WRITE,
        ST_FLUSH_SCAN,
        ST_FLUSH_WB,
        ST_RESP
    } state_t;

    state_t                  state_reg, state_next;
    ckv_pkg::action_t        act_reg, act_next;
    logic [KEY_BITS-1:0]     in_key_reg, in_key_next;
    logic [VALUE_BITS-1:0]   in_data_reg, in_data_next;
    logic                    in_ok_reg, in_ok_next;
    logic [CNT_W-1:0]        scan_reg, scan_next;
    logic                    cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]        cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]        slot_reg, slot_next;
    logic                    ins_dirty_reg, ins_dirty_next;
    logic [ENTRIES-1:0]      ref_marks_reg, ref_marks_next;
    logic [ENTRIES-1:0]      dirty_marks_reg, dirty_marks_next;
    logic [CNT_W-1:0]        filled_count_reg, filled_count_next;
    logic [IDX_W-1:0]        hand_reg, hand_next;
    logic                    awaiting_reg, awaiting_next;
    logic [KEY_BITS-1:0]     pending_key_reg, pending_key_next;
    ckv_pkg::kind_t          resp_kind_reg, resp_kind_next;
    logic [KEY_BITS-1:0]     resp_key_reg, resp_key_next;
    logic [VALUE_BITS-1:0]   resp_data_reg, resp_data_next;
    logic                    resp_fail_reg, resp_fail_next;
    logic                    m_valid_reg, m_valid_next;
    ckv_pkg::kind_t          m_kind_reg, m_kind_next;
    logic [KEY_BITS-1:0]     m_key_reg, m_key_next;
    logic [VALUE_BITS-1:0]   m_data_reg, m_data_next;
    logic                    m_failed_reg, m_failed_next;
    logic                    m_last_reg, m_last_next;

    logic             out_free;
    logic             hit;
    logic [IDX_W-1:0] hand_eff;
    logic [IDX_W-1:0] hand_inc;

    // Hand restarts at zero when it sits at or beyond the capacity
    assign hand_eff = (CNT_W'(hand_reg) >= cap) ? '0 : hand_reg;
    assign hand_inc = ((CNT_W'(hand_eff) + 1'b1) == cap) ? '0 : IDX_W'(hand_eff + 1'b1);

    assign out_free = !m_valid_reg || m_ready;
    assign hit      = cmp_valid_reg && (key_rdata == in_key_reg);

    // Sequencer: one slot per cycle through the RAM read port in the key search; flush writebacks wait for the output
    always_comb begin
        state_next        = state_reg;
        act_next          = act_reg;
        in_key_next       = in_key_reg;
        in_data_next      = in_data_reg;
        in_ok_next        = in_ok_reg;
        scan_next         = scan_reg;
        cmp_valid_next    = cmp_valid_reg;
        cmp_idx_next      = cmp_idx_reg;
        slot_next         = slot_reg;
        ins_dirty_next    = ins_dirty_reg;
        ref_marks_next    = ref_marks_reg;
        dirty_marks_next  = dirty_marks_reg;
        filled_count_next = filled_count_reg;
        hand_next         = hand_reg;
        awaiting_next     = awaiting_reg;
        pending_key_next  = pending_key_reg;
        resp_kind_next    = resp_kind_reg;
        resp_key_next     = resp_key_reg;
        resp_data_next    = resp_data_reg;
        resp_fail_next    = resp_fail_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_kind_next       = m_kind_reg;
        m_key_next        = m_key_reg;
        m_data_next       = m_data_reg;
        m_failed_next     = m_failed_reg;
        m_last_next       = m_last_reg;
        ram_ctl           = '0;
        ram_waddr         = slot_reg;
        ram_raddr         = scan_reg[IDX_W-1:0];
        key_wdata         = in_key_reg;
        val_wdata         = in_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    act_next     = ckv_pkg::action_t'(s_action);
                    in_key_next  = s_key;
                    in_data_next = s_data_in;
                    in_ok_next   = s_fetch_ok;
                    state_next   = ST_DISPATCH;
                end
            end

            ST_DISPATCH: begin
                resp_kind_next = ckv_pkg::KIND_STATUS;
                resp_key_next  = in_key_reg;
                resp_data_next = '0;
                resp_fail_next = 1'b0;
                if (awaiting_reg) begin
                    if (act_reg != ckv_pkg::ACT_FILL) begin
                        resp_fail_next = 1'b1;
                        state_next     = ST_RESP;
                    end else begin
                        awaiting_next = 1'b0;
                        resp_key_next = pending_key_reg;
                        if (!in_ok_reg) begin
                            resp_fail_next = 1'b1;
                            state_next     = ST_RESP;
                        end else begin
                            in_key_next    = pending_key_reg;
                            resp_kind_next = ckv_pkg::KIND_READ;
                            resp_data_next = in_data_reg;
                            ins_dirty_next = 1'b0;
                            state_next     = ST_INSTALL;
                        end
                    end
                end else begin
                    unique case (act_reg)
                        ckv_pkg::ACT_GET, ckv_pkg::ACT_SET: begin
                            scan_next      = '0;
                            cmp_valid_next = 1'b0;
                            state_next     = ST_LOOK;
                        end
                        ckv_pkg::ACT_FILL: begin
                            resp_fail_next = 1'b1;
                            state_next     = ST_RESP;
                        end
                        ckv_pkg::ACT_FLUSH: begin
                            resp_key_next = '0;
                            scan_next     = '0;
                            state_next    = ST_FLUSH_SCAN;
                        end
                    endcase
                end
            end

            // Compare the slot read last cycle while reading the next one
            ST_LOOK: begin
                if (hit) begin
                    cmp_valid_next              = 1'b0;
                    ref_marks_next[cmp_idx_reg] = 1'b1;
                    if (act_reg == ckv_pkg::ACT_GET) begin
                        resp_kind_next = ckv_pkg::KIND_READ;
                        resp_data_next = val_rdata;
                    end else begin
                        ram_ctl.wr_en                 = 1'b1;
                        ram_waddr                     = cmp_idx_reg;
                        dirty_marks_next[cmp_idx_reg] = 1'b1;
                    end
                    state_next = ST_RESP;
                end else if (scan_reg < filled_count_reg) begin
                    ram_ctl.rd_en  = 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_reg[IDX_W-1:0];
                    scan_next      = scan_reg + 1'b1;
                end else begin
                    cmp_valid_next = 1'b0;
                    if (!cmp_valid_reg) begin
                        if (act_reg == ckv_pkg::ACT_GET) begin
                            awaiting_next    = 1'b1;
                            pending_key_next = in_key_reg;
                            resp_kind_next   = ckv_pkg::KIND_FETCH;
                            state_next       = ST_RESP;
                        end else begin
                            ins_dirty_next = 1'b1;
                            state_next     = ST_INSTALL;
                        end
                    end
                end
            end

            // Take a free slot first, else run the clock hand
            ST_INSTALL: begin
                if (filled_count_reg < cap) begin
                    slot_next         = filled_count_reg[IDX_W-1:0];
                    filled_count_next = filled_count_reg + 1'b1;
                    state_next        = ST_WRITE;
                end else begin
                    state_next = ST_HAND;
                end
            end

            ST_HAND: begin
                hand_next = hand_inc;
                if (ref_marks_reg[hand_eff]) begin
                    ref_marks_next[hand_eff] = 1'b0;
                end else begin
                    slot_next = hand_eff;
                    if (dirty_marks_reg[hand_eff]) begin
                        ram_ctl.rd_en = 1'b1;
                        ram_raddr     = hand_eff;
                        state_next    = ST_VICTIM_WB;
                    end else begin
                        state_next = ST_WRITE;
                    end
                end
            end

            ST_VICTIM_WB: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_kind_next   = ckv_pkg::KIND_WB;
                    m_key_next    = key_rdata;
                    m_data_next   = val_rdata;
                    m_failed_next = 1'b0;
                    m_last_next   = 1'b0;
                    state_next    = ST_WRITE;
                end
            end

            ST_WRITE: begin
                ram_ctl.wr_en              = 1'b1;
                ref_marks_next[slot_reg]   = 1'b1;
                dirty_marks_next[slot_reg] = ins_dirty_reg;
                state_next                 = ST_RESP;
            end

            // Skip clean slots; read out each dirty one
            ST_FLUSH_SCAN: begin
                if (scan_reg < filled_count_reg) begin
                    if (dirty_marks_reg[scan_reg[IDX_W-1:0]]) begin
                        ram_ctl.rd_en = 1'b1;
                        state_next    = ST_FLUSH_WB;
                    end else begin
                        scan_next = scan_reg + 1'b1;
                    end
                end else begin
                    state_next = ST_RESP;
                end
            end

            ST_FLUSH_WB: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_kind_next   = ckv_pkg::KIND_WB;
                    m_key_next    = key_rdata;
                    m_data_next   = val_rdata;
                    m_failed_next = 1'b0;
                    m_last_next   = 1'b0;
                    dirty_marks_next[scan_reg[IDX_W-1:0]] = 1'b0;
                    scan_next     = scan_reg + 1'b1;
                    state_next    = ST_FLUSH_SCAN;
                end
            end

            ST_RESP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_kind_next   = resp_kind_reg;
                    m_key_next    = resp_key_reg;
                    m_data_next   = resp_data_reg;
                    m_failed_next = resp_fail_reg;
                    m_last_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, marks and the output beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            ref_marks_reg    <= '0;
            dirty_marks_reg  <= '0;
            filled_count_reg <= '0;
            hand_reg         <= '0;
            awaiting_reg     <= 1'b0;
            pending_key_reg  <= '0;
            cmp_valid_reg    <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            ref_marks_reg    <= ref_marks_next;
            dirty_marks_reg  <= dirty_marks_next;
            filled_count_reg <= filled_count_next;
            hand_reg         <= hand_next;
            awaiting_reg     <= awaiting_next;
            pending_key_reg  <= pending_key_next;
            cmp_valid_reg    <= cmp_valid_next;
            m_valid_reg      <= m_valid_next;
        end
        act_reg       <= act_next;
        in_key_reg    <= in_key_next;
        in_data_reg   <= in_data_next;
        in_ok_reg     <= in_ok_next;
        scan_reg      <= scan_next;
        cmp_idx_reg   <= cmp_idx_next;
        slot_reg      <= slot_next;
        ins_dirty_reg <= ins_dirty_next;
        resp_kind_reg <= resp_kind_next;
        resp_key_reg  <= resp_key_next;
        resp_data_reg <= resp_data_next;
        resp_fail_reg <= resp_fail_next;
        m_kind_reg    <= m_kind_next;
        m_key_reg     <= m_key_next;
        m_data_reg    <= m_data_next;
        m_failed_reg  <= m_failed_next;
        m_last_reg    <= m_last_next;
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_kind     = m_kind_reg;
    assign m_key_out  = m_key_reg;
    assign m_data_out = m_data_reg;
    assign m_failed   = m_failed_reg;
    assign m_last     = m_last_reg;

    // An item whose final beat is not yet out keeps the input closed
    a_last_before_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_last_reg) |-> (state_reg != ST_IDLE))
        else $error("input opened before final result beat");

    // Waiting for a fill starts together with a queued fetch request
    a_fetch_on_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(awaiting_reg) |->
            (state_reg == ST_RESP && resp_kind_reg == ckv_pkg::KIND_FETCH))
        else $error("fill wait without fetch request");

    // Writeback beats are never final
    a_wb_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_kind_reg == ckv_pkg::KIND_WB) |-> !m_last_reg)
        else $error("writeback beat marked last");

    // Fill count never passes the slot count
    a_filled_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        filled_count_reg <= CNT_W'(ENTRIES))
        else $error("fill count beyond slot count");

endmodule

>>> rtl/clock_writeback_kv_cache.sv
`timescale 1ns / 1ps
// A get or set searches the filled slots through the key RAM read port before its final
// beat; a miss install adds a clock sweep, a victim writeback and the slot write. A flush
// scans the filled slots and emits a writeback beat per dirty slot. Every result beat may
// stall while m_ready is low.
// Throughput: one item at a time; the search through the key RAM read port sets the rate.
// Reset (aresetn low, synchronous): cache empty, all marks clear, hand at zero,
// no fill pending, capacity register at 16. No clearing pass.
module clock_writeback_kv_cache #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [ckv_pkg::CFG_BITS-1:0] cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_action,
    input  logic [KEY_BITS-1:0]          s_key,
    input  logic [VALUE_BITS-1:0]        s_data_in,
    input  logic                         s_fetch_ok,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_kind,
    output logic [KEY_BITS-1:0]          m_key_out,
    output logic [VALUE_BITS-1:0]        m_data_out,
    output logic                         m_failed,
    output logic                         m_last
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic [ckv_pkg::CFG_BITS-1:0] cfg_reg;
    logic [CNT_W-1:0]             cap;
    ckv_pkg::ram_ctl_t            ram_ctl;
    logic [IDX_W-1:0]             ram_waddr;
    logic [IDX_W-1:0]             ram_raddr;
    logic [KEY_BITS-1:0]          key_wdata;
    logic [KEY_BITS-1:0]          key_rdata;
    logic [VALUE_BITS-1:0]        val_wdata;
    logic [VALUE_BITS-1:0]        val_rdata;

    // Hold the capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= ckv_pkg::CFG_RESET;
        end else if (cfg_wr_en) begin
            cfg_reg <= cfg_wr_data;
        end
    end

    // Clamp capacity to one through the slot count
    always_comb begin
        if (cfg_reg == '0) begin
            cap = CNT_W'(1);
        end else if (int'(cfg_reg) > ENTRIES) begin
            cap = CNT_W'(ENTRIES);
        end else begin
            cap = CNT_W'(cfg_reg);
        end
    end

    ckv_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .aclk  (aclk),
        .ctl   (ram_ctl),
        .waddr (ram_waddr),
        .wdata (key_wdata),
        .raddr (ram_raddr),
        .rdata (key_rdata)
    );

    ckv_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (ENTRIES)
    ) u_val_ram (
        .aclk  (aclk),
        .ctl   (ram_ctl),
        .waddr (ram_waddr),
        .wdata (val_wdata),
        .raddr (ram_raddr),
        .rdata (val_rdata)
    );

    ckv_ctrl #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cap        (cap),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_action   (s_action),
        .s_key      (s_key),
        .s_data_in  (s_data_in),
        .s_fetch_ok (s_fetch_ok),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_kind     (m_kind),
        .m_key_out  (m_key_out),
        .m_data_out (m_data_out),
        .m_failed   (m_failed),
        .m_last     (m_last),
        .ram_ctl    (ram_ctl),
        .ram_waddr  (ram_waddr),
        .key_wdata  (key_wdata),
        .val_wdata  (val_wdata),
        .ram_raddr  (ram_raddr),
        .key_rdata  (key_rdata),
        .val_rdata  (val_rdata)
    );

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int NSLOT         = 16;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_ITEMS   = 24;

    // One result beat as the cache should emit it
    typedef struct packed {
        ckv_pkg::kind_t kind;
        logic [63:0]    key;
        logic [63:0]    data;
        logic           failed;
        logic           last;
    } cache_res_t;

    // One row of the directed table: either a capacity write or an item
    typedef struct {
        bit               is_cfg;
        logic [4:0]       cfg_val;
        ckv_pkg::action_t act;
        logic [63:0]      key;
        logic [63:0]      data;
        bit               ok;
        bit               typed;
        cache_res_t       res;
    } stim_row_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [4:0]  cfg_wr_data = 5'd0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [1:0]  s_action    = 2'd0;
    logic [63:0] s_key       = 64'd0;
    logic [63:0] s_data_in   = 64'd0;
    logic        s_fetch_ok  = 1'b0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [1:0]  m_kind;
    logic [63:0] m_key_out;
    logic [63:0] m_data_out;
    logic        m_failed;
    logic        m_last;

    // Typed expectation travelling with the current input beat
    bit          cur_typed = 1'b0;
    cache_res_t  cur_res   = '0;

    // Shadow cache state
    logic [63:0] slot_key [NSLOT];
    logic [63:0] slot_val [NSLOT];
    bit          ref_m    [NSLOT];
    bit          dirty_m  [NSLOT];
    int unsigned fill_n   = 0;
    int unsigned hand     = 0;
    bit          waiting  = 1'b0;
    logic [63:0] wait_key = 64'd0;
    logic [4:0]  cap_reg  = ckv_pkg::CFG_RESET;

    cache_res_t  resp_q [$];
    int unsigned mism_cnt  = 0;
    int unsigned cycle_cnt = 0;
    int unsigned burst_left = 0;

    // Receiver pattern and long hold-off
    bit          hold_req  = 1'b0;
    bit          hold_done = 1'b0;
    int unsigned hold_left = 0;
    int unsigned rx_cnt    = 0;
    int unsigned rx_mode   = 0;
    logic [2:0]  rx_phase  = 3'd0;

    stim_row_t   dir_q [$];

    clock_writeback_kv_cache dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_key       (s_key),
        .s_data_in   (s_data_in),
        .s_fetch_ok  (s_fetch_ok),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_key_out   (m_key_out),
        .m_data_out  (m_data_out),
        .m_failed    (m_failed),
        .m_last      (m_last)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        for (int i = 0; i < NSLOT; i++) begin
            slot_key[i] = 64'd0;
            slot_val[i] = 64'd0;
            ref_m[i]    = 1'b0;
            dirty_m[i]  = 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Shadow model of the cache
    // ---------------------------------------------------------------

    function automatic int unsigned cap_now();
        if (cap_reg == 5'd0) return 1;
        if (cap_reg > NSLOT) return NSLOT;
        return cap_reg;
    endfunction

    // Lowest matching filled slot, or -1
    function automatic int find_slot(logic [63:0] k);
        for (int i = 0; i < fill_n; i++)
            if (slot_key[i] == k) return i;
        return -1;
    endfunction

    function automatic void push_res(ckv_pkg::kind_t kd, logic [63:0] k, logic [63:0] d,
                                     logic f, logic l);
        cache_res_t r;
        r = '{kd, k, d, f, l};
        resp_q.push_back(r);
    endfunction

    // Take a free slot, else sweep the hand; write back a dirty victim
    function automatic void place_entry(logic [63:0] k, logic [63:0] v, bit dirty);
        int unsigned c;
        int unsigned s;
        c = cap_now();
        if (fill_n < c) begin
            s = fill_n;
            fill_n++;
        end else begin
            if (hand >= c) hand = 0;
            while (ref_m[hand]) begin
                ref_m[hand] = 1'b0;
                hand = (hand + 1) % c;
            end
            s = hand;
            if (dirty_m[s])
                push_res(ckv_pkg::KIND_WB, slot_key[s], slot_val[s], 1'b0, 1'b0);
            hand = (hand + 1) % c;
        end
        slot_key[s] = k;
        slot_val[s] = v;
        ref_m[s]    = 1'b1;
        dirty_m[s]  = dirty;
    endfunction

    function automatic void predict_item(ckv_pkg::action_t a, logic [63:0] k,
                                         logic [63:0] v, bit ok);
        int hit;
        if (waiting) begin
            if (a != ckv_pkg::ACT_FILL) begin
                push_res(ckv_pkg::KIND_STATUS, k, 64'd0, 1'b1, 1'b1);
            end else begin
                waiting = 1'b0;
                if (!ok) begin
                    push_res(ckv_pkg::KIND_STATUS, wait_key, 64'd0, 1'b1, 1'b1);
                end else begin
                    place_entry(wait_key, v, 1'b0);
                    push_res(ckv_pkg::KIND_READ, wait_key, v, 1'b0, 1'b1);
                end
            end
            return;
        end
        case (a)
            ckv_pkg::ACT_GET: begin
                hit = find_slot(k);
                if (hit >= 0) begin
                    ref_m[hit] = 1'b1;
                    push_res(ckv_pkg::KIND_READ, k, slot_val[hit], 1'b0, 1'b1);
                end else begin
                    waiting  = 1'b1;
                    wait_key = k;
                    push_res(ckv_pkg::KIND_FETCH, k, 64'd0, 1'b0, 1'b1);
                end
            end
            ckv_pkg::ACT_SET: begin
                hit = find_slot(k);
                if (hit >= 0) begin
                    slot_val[hit] = v;
                    ref_m[hit]    = 1'b1;
                    dirty_m[hit]  = 1'b1;
                end else begin
                    place_entry(k, v, 1'b1);
                end
                push_res(ckv_pkg::KIND_STATUS, k, 64'd0, 1'b0, 1'b1);
            end
            ckv_pkg::ACT_FILL: begin
                push_res(ckv_pkg::KIND_STATUS, k, 64'd0, 1'b1, 1'b1);
            end
            default: begin
                for (int i = 0; i < fill_n; i++) begin
                    if (dirty_m[i]) begin
                        push_res(ckv_pkg::KIND_WB, slot_key[i], slot_val[i], 1'b0, 1'b0);
                        dirty_m[i] = 1'b0;
                    end
                end
                push_res(ckv_pkg::KIND_STATUS, 64'd0, 64'd0, 1'b0, 1'b1);
            end
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Scoreboard: predict on input beats, compare on output beats
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        cache_res_t  got;
        cache_res_t  want;
        int unsigned n0;
        if (aresetn) begin
            if (cfg_wr_en) cap_reg = cfg_wr_data;
            if (s_valid && s_ready) begin
                n0 = resp_q.size();
                predict_item(ckv_pkg::action_t'(s_action), s_key, s_data_in, s_fetch_ok);
                // Replace the prediction by the row's typed value
                if (cur_typed) begin
                    while (resp_q.size() > n0) void'(resp_q.pop_back());
                    resp_q.push_back(cur_res);
                end
            end
            if (m_valid && m_ready) begin
                got = '{ckv_pkg::kind_t'(m_kind), m_key_out, m_data_out, m_failed, m_last};
                if (resp_q.size() == 0) begin
                    mism_cnt++;
                    if (mism_cnt <= 10)
                        $display("unexpected result beat: kind=%0d key=%h data=%h failed=%b last=%b",
                                 got.kind, got.key, got.data, got.failed, got.last);
                end else begin
                    want = resp_q.pop_front();
                    if (got !== want) begin
                        mism_cnt++;
                        if (mism_cnt <= 10) begin
                            $display("mismatch exp: kind=%0d key=%h data=%h failed=%b last=%b",
                                     want.kind, want.key, want.data, want.failed, want.last);
                            $display("         got: kind=%0d key=%h data=%h failed=%b last=%b",
                                     got.kind, got.key, got.data, got.failed, got.last);
                        end
                    end
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: switch stall pattern now and then; hold off once for a long stretch
    always @(posedge aclk) begin
        rx_phase <= rx_phase + 3'd1;
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            if (rx_cnt == 0) begin
                rx_cnt  <= $urandom_range(20, 80);
                rx_mode <= $urandom_range(0, 3);
            end else begin
                rx_cnt <= rx_cnt - 1;
            end
            case (rx_mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= $urandom_range(0, 1);
                2:       m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= rx_phase[2];
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    function automatic stim_row_t op_row(ckv_pkg::action_t a, logic [63:0] k,
                                         logic [63:0] d, bit ok);
        stim_row_t r;
        r.is_cfg  = 1'b0;
        r.cfg_val = 5'd0;
        r.act     = a;
        r.key     = k;
        r.data    = d;
        r.ok      = ok;
        r.typed   = 1'b0;
        r.res     = '{ckv_pkg::KIND_STATUS, 64'd0, 64'd0, 1'b0, 1'b0};
        return r;
    endfunction

    // Item row with a single, obvious result
    function automatic stim_row_t chk_row(ckv_pkg::action_t a, logic [63:0] k,
                                          logic [63:0] d, bit ok,
                                          ckv_pkg::kind_t kd, logic [63:0] rk,
                                          logic [63:0] rd, logic rf);
        stim_row_t r;
        r       = op_row(a, k, d, ok);
        r.typed = 1'b1;
        r.res   = '{kd, rk, rd, rf, 1'b1};
        return r;
    endfunction

    function automatic stim_row_t cap_row(logic [4:0] v);
        stim_row_t r;
        r         = op_row(ckv_pkg::ACT_GET, 64'd0, 64'd0, 1'b0);
        r.is_cfg  = 1'b1;
        r.cfg_val = v;
        return r;
    endfunction

    // Offer one input beat, in bursts with random gaps, and wait for acceptance
    task automatic send_item(ckv_pkg::action_t a, logic [63:0] k, logic [63:0] d, bit ok,
                             bit typed, cache_res_t r);
        int unsigned gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 12);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid    <= 1'b1;
        s_action   <= a;
        s_key      <= k;
        s_data_in  <= d;
        s_fetch_ok <= ok;
        cur_typed  <= typed;
        cur_res    <= r;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop offering and wait until the cache has gone quiet
    task automatic settle();
        s_valid    <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (resp_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_cap(logic [4:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [63:0] pick_key(int unsigned pool);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80) return 64'(($urandom_range(0, pool - 1)) * 64'h9E37_79B9_7F4A_7C15);
        if (r < 90) return {$urandom, $urandom};
        if (r < 95) return 64'd0;
        return '1;
    endfunction

    // Mostly get/fill pairs and sets over a small key pool, with stray items mixed in
    task automatic random_phase(int unsigned n, int unsigned pool);
        ckv_pkg::action_t a;
        bit               prev_get;
        int unsigned      r;
        prev_get = 1'b0;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (prev_get && r < 85)  a = ckv_pkg::ACT_FILL;
            else if (r < 42)         a = ckv_pkg::ACT_GET;
            else if (r < 82)         a = ckv_pkg::ACT_SET;
            else if (r < 90)         a = ckv_pkg::ACT_FLUSH;
            else                     a = ckv_pkg::ACT_FILL;
            send_item(a, pick_key(pool), {$urandom, $urandom},
                      ($urandom_range(0, 4) != 0), 1'b0, '0);
            prev_get = (a == ckv_pkg::ACT_GET);
        end
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        int unsigned caps [8];
        int unsigned ceff;
        caps = '{0, 31, 5, 17, 2, 16, 9, 1};

        // Directed rows at the reset capacity
        dir_q.push_back(chk_row(ckv_pkg::ACT_GET, 64'd0, 64'd0, 1'b0,
                                ckv_pkg::KIND_FETCH, 64'd0, 64'd0, 1'b0));
        dir_q.push_back(chk_row(ckv_pkg::ACT_FILL, 64'd5, 64'hDEAD, 1'b0,
                                ckv_pkg::KIND_STATUS, 64'd0, 64'd0, 1'b1));
        dir_q.push_back(chk_row(ckv_pkg::ACT_FILL, '1, '1, 1'b1,
                                ckv_pkg::KIND_STATUS, '1, 64'd0, 1'b1));
        dir_q.push_back(chk_row(ckv_pkg::ACT_SET, '1, '1, 1'b0,
                                ckv_pkg::KIND_STATUS, '1, 64'd0, 1'b0));
        dir_q.push_back(chk_row(ckv_pkg::ACT_GET, '1, 64'd0, 1'b0,
                                ckv_pkg::KIND_READ, '1, '1, 1'b0));
        dir_q.push_back(chk_row(ckv_pkg::ACT_SET, 64'd0, 64'd0, 1'b1,
                                ckv_pkg::KIND_STATUS, 64'd0, 64'd0, 1'b0));
        dir_q.push_back(chk_row(ckv_pkg::ACT_SET, '1, 64'h5555_5555_5555_5555, 1'b0,
                                ckv_pkg::KIND_STATUS, '1, 64'd0, 1'b0));
        dir_q.push_back(chk_row(ckv_pkg::ACT_GET, 64'h1234, 64'd0, 1'b0,
                                ckv_pkg::KIND_FETCH, 64'h1234, 64'd0, 1'b0));
        // Non-fill items while a fetch is outstanding
        dir_q.push_back(chk_row(ckv_pkg::ACT_SET, 64'd7, 64'd9, 1'b0,
                                ckv_pkg::KIND_STATUS, 64'd7, 64'd0, 1'b1));
        dir_q.push_back(chk_row(ckv_pkg::ACT_FLUSH, 64'hAAAA_AAAA_AAAA_AAAA, 64'd0, 1'b0,
                                ckv_pkg::KIND_STATUS, 64'hAAAA_AAAA_AAAA_AAAA, 64'd0,
                                1'b1));
        // Good fill ignores its own key
        dir_q.push_back(chk_row(ckv_pkg::ACT_FILL, 64'd999, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1,
                                ckv_pkg::KIND_READ, 64'h1234, 64'hAAAA_AAAA_AAAA_AAAA,
                                1'b0));
        dir_q.push_back(op_row(ckv_pkg::ACT_GET, 64'h1234, 64'd0, 1'b0));
        dir_q.push_back(op_row(ckv_pkg::ACT_FLUSH, 64'd0, 64'd0, 1'b0));
        dir_q.push_back(chk_row(ckv_pkg::ACT_FLUSH, '1, '1, 1'b1,
                                ckv_pkg::KIND_STATUS, 64'd0, 64'd0, 1'b0));
        // Small capacity: force sweeps, clean and dirty victims
        dir_q.push_back(cap_row(5'd4));
        dir_q.push_back(op_row(ckv_pkg::ACT_SET, 64'h1234, 64'h0F0F_0F0F_0F0F_0F0F, 1'b0));
        dir_q.push_back(chk_row(ckv_pkg::ACT_SET, 64'h20, 64'd1, 1'b0,
                                ckv_pkg::KIND_STATUS, 64'h20, 64'd0, 1'b0));
        dir_q.push_back(op_row(ckv_pkg::ACT_SET, 64'h21, 64'd2, 1'b0));
        dir_q.push_back(op_row(ckv_pkg::ACT_SET, 64'h22, 64'd3, 1'b0));
        dir_q.push_back(op_row(ckv_pkg::ACT_SET, 64'h23, 64'd4, 1'b0));
        dir_q.push_back(chk_row(ckv_pkg::ACT_GET, 64'h55, 64'd0, 1'b0,
                                ckv_pkg::KIND_FETCH, 64'h55, 64'd0, 1'b0));
        dir_q.push_back(op_row(ckv_pkg::ACT_FILL, 64'd0, 64'h77, 1'b1));
        dir_q.push_back(op_row(ckv_pkg::ACT_FLUSH, 64'd0, 64'd0, 1'b0));
        // Drop capacity below the filled count
        dir_q.push_back(cap_row(5'd1));
        dir_q.push_back(op_row(ckv_pkg::ACT_SET, 64'h21, 64'd8, 1'b0));
        dir_q.push_back(op_row(ckv_pkg::ACT_SET, 64'h99, 64'd6, 1'b0));

        // Hold reset low before releasing it
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed table
        foreach (dir_q[i]) begin
            if (dir_q[i].is_cfg) begin
                settle();
                write_cap(dir_q[i].cfg_val);
            end else begin
                send_item(dir_q[i].act, dir_q[i].key, dir_q[i].data, dir_q[i].ok,
                          dir_q[i].typed, dir_q[i].res);
            end
        end

        // Random phases, one capacity each
        foreach (caps[p]) begin
            settle();
            write_cap(5'(caps[p]));
            ceff = (caps[p] == 0) ? 1 : ((caps[p] > NSLOT) ? NSLOT : caps[p]);
            // Fill up the cache while the receiver holds off
            if (caps[p] == 31) hold_req <= 1'b1;
            random_phase(PHASE_ITEMS, ceff + $urandom_range(1, 8));
        end

        settle();
        if (mism_cnt == 0 && resp_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/ckv_pkg.sv
rtl/ckv_ram.sv
rtl/ckv_ctrl.sv
rtl/clock_writeback_kv_cache.sv
dv/tb.sv
